@@ hdl/assert_macros.svh @@
// concurrent assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wsff_pkg.sv @@
package wsff_pkg;

    localparam int CFG_BITS     = 10;
    localparam int CFG_IDX_BITS = 1;
    localparam int MODE_BITS    = 2;
    localparam int SPEED_BITS   = 12;
    localparam int BLEND_BITS   = 15;

    localparam int STAND_RESET  = 110;
    localparam int THREE_RESET  = 120;
    localparam int JUMP_LIMIT   = 20;
    localparam int SPEED_FLOOR  = -30;
    localparam int SPEED_MARGIN = 30;
    localparam int D_MAX        = 19661;
    localparam int DQ_LIMIT     = 20;
    localparam int Q16_HALF     = 32768;
    localparam int Q16_ROUND    = 65535;
    localparam int Q16_SHIFT    = 16;
    localparam int BLEND_ROUND  = 2;

    localparam int DIV_DIGITS   = 4;
    localparam int DIV_REM_BITS = 4;
    localparam int DIVISOR_TEN  = 10;
    localparam int DIVISOR_FIVE = 5;

    localparam logic [MODE_BITS-1:0]    MODE_STAND = 2'd0;
    localparam logic [MODE_BITS-1:0]    MODE_THREE = 2'd1;

    localparam logic [CFG_IDX_BITS-1:0] REG_STAND_TARGET = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THREE_TARGET = 1'b1;

    typedef enum logic {
        DIV_TEN,
        DIV_FIVE
    } t_div_sel;

    typedef struct packed {
        logic     start;
        t_div_sel sel;
    } t_div_req;

    // floor(k*k * 65536 / 1400) for a wheel deviation gap of k
    function automatic logic [BLEND_BITS-1:0] dq_lookup(input logic [4:0] k);
        logic [BLEND_BITS-1:0] r;
        case (k)
            5'd0:    r = 15'd0;
            5'd1:    r = 15'd46;
            5'd2:    r = 15'd187;
            5'd3:    r = 15'd421;
            5'd4:    r = 15'd748;
            5'd5:    r = 15'd1170;
            5'd6:    r = 15'd1685;
            5'd7:    r = 15'd2293;
            5'd8:    r = 15'd2995;
            5'd9:    r = 15'd3791;
            5'd10:   r = 15'd4681;
            5'd11:   r = 15'd5664;
            5'd12:   r = 15'd6740;
            5'd13:   r = 15'd7911;
            5'd14:   r = 15'd9175;
            5'd15:   r = 15'd10532;
            5'd16:   r = 15'd11983;
            5'd17:   r = 15'd13528;
            5'd18:   r = 15'd15166;
            5'd19:   r = 15'd16898;
            5'd20:   r = 15'd18724;
            default: r = BLEND_BITS'(D_MAX);
        endcase
        return r;
    endfunction

endpackage

@@ hdl/wsff_if.sv @@
interface wsff_in_if import wsff_pkg::*; #(
    parameter int PULSE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PULSE_BITS-1:0] raw_left;
    logic signed [PULSE_BITS-1:0] raw_right;
    logic        [MODE_BITS-1:0]  mode;

    modport source (output valid, output raw_left, output raw_right, output mode,
                    input ready);
    modport sink   (input valid, input raw_left, input raw_right, input mode,
                    output ready);
endinterface

interface wsff_out_if import wsff_pkg::*; #(
    parameter int PULSE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] car_speed;
    logic signed [PULSE_BITS-1:0] filtered_left;
    logic signed [PULSE_BITS-1:0] filtered_right;

    modport source (output valid, output car_speed, output filtered_left,
                    output filtered_right, input ready);
    modport sink   (input valid, input car_speed, input filtered_left,
                    input filtered_right, output ready);
endinterface

interface wsff_cfg_if import wsff_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/wsff_cdiv.sv @@
module wsff_cdiv import wsff_pkg::*; #(
    parameter int W = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_req     i_req,
    input  logic [W-1:0] i_dividend,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int WP   = ((W + DIV_DIGITS - 1) / DIV_DIGITS) * DIV_DIGITS;
    localparam int NCYC = WP / DIV_DIGITS;
    localparam int CNTW = $clog2(NCYC + 1);

    logic [WP-1:0]           r_q;
    logic [WP-1:0]           n_q;
    logic [DIV_REM_BITS-1:0] r_rem;
    logic [DIV_REM_BITS-1:0] n_rem;
    logic [DIV_REM_BITS-1:0] r_dv;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_busy;
    logic                    r_done;

    // restoring division, several quotient bits per cycle
    always_comb begin
        logic [DIV_REM_BITS:0] v_t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_DIGITS; k++) begin
            v_t = {n_rem, n_q[WP-1]};
            n_q = {n_q[WP-2:0], 1'b0};
            if (v_t >= {1'b0, r_dv}) begin
                v_t    = v_t - {1'b0, r_dv};
                n_q[0] = 1'b1;
            end
            n_rem = v_t[DIV_REM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= WP'(i_dividend);
                r_rem  <= '0;
                r_cnt  <= CNTW'(NCYC);
                r_busy <= 1'b1;
                case (i_req.sel)
                    DIV_TEN:  r_dv <= DIV_REM_BITS'(DIVISOR_TEN);
                    DIV_FIVE: r_dv <= DIV_REM_BITS'(DIVISOR_FIVE);
                    default:  r_dv <= DIV_REM_BITS'(DIVISOR_TEN);
                endcase
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q[W-1:0];

endmodule

@@ hdl/wheel_speed_filter_fusion_top.sv @@
// Wheel speed filter and fusion. Each input item holds one sample period of left and right
// encoder counts plus a mode; the right count is negated (most negative saturates). Each
// wheel is smoothed against its last filtered value, then stand mode reports the mean of
// the wheels and three mode weights the faster wheel by 0.5 plus a smoothed unevenness term;
// other modes hold the last speed. Every item gives exactly one result item. One item is
// worked on at a time, and the block takes no new item until the result sits in the output
// register. A shared max(PULSE_BITS+3, 17)-bit divide-by-constant unit (4 quotient bits a
// cycle) does each /10 of the wheel smoothing and the /5 of the blend; a single 18-bit by
// PULSE_BITS multiplier is used twice for the three mode weighting. Configuration writes
// are taken at any time, ready stays high.
module wheel_speed_filter_fusion_top import wsff_pkg::*; #(
    parameter int PULSE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsff_in_if.sink     i_item,
    wsff_out_if.source  o_res,
    wsff_cfg_if.sink    i_cfg
);
    `include "assert_macros.svh"

    localparam int P  = PULSE_BITS;
    localparam int DW = (P + 3 > 17) ? P + 3 : 17;
    localparam int EW = ((P > 10) ? P : 10) + 2;
    localparam int AW = P + 18;
    localparam int CW = ((P > 11) ? P : 11) + 4;

    localparam logic [P-1:0]        P_MIN    = {1'b1, {(P-1){1'b0}}};
    localparam logic [P-1:0]        P_MAX    = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P:0]   JUMP_POS = (P+1)'(JUMP_LIMIT);
    localparam logic signed [P:0]   JUMP_NEG = -JUMP_POS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMOOTH,
        S_SDIV,
        S_MODE,
        S_BDIV,
        S_MUL_A,
        S_MUL_B,
        S_FIN,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CFG_BITS-1:0]      r_stand;
    logic [CFG_BITS-1:0]      r_three;
    logic signed [P-1:0]      r_raw_l;
    logic signed [P-1:0]      r_raw_r;
    logic [MODE_BITS-1:0]     r_mode;
    logic                     r_wheel;
    logic                     r_sneg;
    logic signed [P-1:0]      r_prev_l;
    logic signed [P-1:0]      r_prev_r;
    logic [BLEND_BITS-1:0]    r_blend;
    logic [SPEED_BITS-1:0]    r_held;
    logic signed [AW-1:0]     r_acc;
    logic                     r_o_valid;
    logic [SPEED_BITS-1:0]    r_o_speed;
    logic signed [P-1:0]      r_o_fl;
    logic signed [P-1:0]      r_o_fr;

    logic signed [P-1:0]      w_neg_right;
    logic signed [P-1:0]      w_now;
    logic signed [P-1:0]      w_old;
    logic signed [P:0]        w_jump;
    logic                     w_small;
    logic signed [P+3:0]      w_sum9;
    logic [P+3:0]             w_mag9;
    logic signed [P:0]        w_sum2;
    logic [P:0]               w_sum2r;
    logic signed [P-1:0]      w_half;
    logic [P-1:0]             w_qm;
    logic signed [P-1:0]      w_qs;
    logic signed [P:0]        w_ssum;
    logic [P:0]               w_ssumr;
    logic signed [P-1:0]      w_avg;
    logic signed [EW-1:0]     w_dl;
    logic signed [EW-1:0]     w_dr;
    logic [EW-1:0]            w_al;
    logic [EW-1:0]            w_ar;
    logic signed [EW:0]       w_gap;
    logic [EW:0]              w_gmag;
    logic [BLEND_BITS-1:0]    w_dq;
    logic [16:0]              w_bx;
    logic                     w_left_fast;
    logic                     w_use_left;
    logic signed [P-1:0]      w_mul_a;
    logic signed [17:0]       w_mul_b;
    logic signed [AW-1:0]     w_prod;
    logic signed [AW-1:0]     w_accr;
    logic signed [P+1:0]      w_spd_mul;
    logic                     w_out_free;
    t_div_req                 w_dreq;
    logic [DW-1:0]            w_dividend;
    logic                     w_div_done;
    logic [DW-1:0]            w_quo;

    function automatic logic [SPEED_BITS-1:0] f_clamp(input logic signed [CW-1:0] v,
                                                      input logic [CFG_BITS-1:0] tgt);
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] r;
        hi = $signed(CW'(tgt) + CW'(SPEED_MARGIN));
        lo = $signed(CW'(SPEED_FLOOR));
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[SPEED_BITS-1:0];
    endfunction

    // input capture
    assign w_neg_right = (i_item.raw_right == P_MIN) ? P_MAX : -i_item.raw_right;

    // wheel smoothing, one wheel at a time
    assign w_now   = r_wheel ? r_raw_r : r_raw_l;
    assign w_old   = r_wheel ? r_prev_r : r_prev_l;
    assign w_jump  = {w_now[P-1], w_now} - {w_old[P-1], w_old};
    assign w_small = (w_jump < JUMP_POS) && (w_jump > JUMP_NEG);
    assign w_sum9  = ({{4{w_now[P-1]}}, w_now} <<< 3) + {{4{w_now[P-1]}}, w_now}
                   + {{4{w_old[P-1]}}, w_old};
    assign w_mag9  = w_sum9[P+3] ? -w_sum9 : w_sum9;
    assign w_sum2  = {w_now[P-1], w_now} + {w_old[P-1], w_old};
    assign w_sum2r = w_sum2 + {{P{1'b0}}, w_sum2[P]};
    assign w_half  = w_sum2r[P:1];
    assign w_qm    = w_quo[P-1:0];
    assign w_qs    = r_sneg ? (~w_qm + 1'b1) : w_qm;

    // stand mode mean
    assign w_ssum  = {r_prev_l[P-1], r_prev_l} + {r_prev_r[P-1], r_prev_r};
    assign w_ssumr = w_ssum + {{P{1'b0}}, w_ssum[P]};
    assign w_avg   = w_ssumr[P:1];

    // three mode unevenness and blend
    assign w_dl   = EW'(r_prev_l) - $signed(EW'(r_three));
    assign w_dr   = EW'(r_prev_r) - $signed(EW'(r_three));
    assign w_al   = w_dl[EW-1] ? -w_dl : w_dl;
    assign w_ar   = w_dr[EW-1] ? -w_dr : w_dr;
    assign w_gap  = $signed({1'b0, w_al}) - $signed({1'b0, w_ar});
    assign w_gmag = w_gap[EW] ? -w_gap : w_gap;
    assign w_dq   = (w_gmag <= (EW+1)'(DQ_LIMIT)) ? dq_lookup(w_gmag[4:0])
                                                  : BLEND_BITS'(D_MAX);
    assign w_bx   = {w_dq, 2'b00} + 17'(r_blend) + 17'(BLEND_ROUND);

    // weighting on the shared multiplier
    assign w_left_fast = r_prev_l > r_prev_r;
    assign w_use_left  = (r_state == S_MUL_A) ? w_left_fast : !w_left_fast;
    assign w_mul_a     = w_use_left ? r_prev_l : r_prev_r;
    assign w_mul_b     = (r_state == S_MUL_A) ? $signed(18'(Q16_HALF) + 18'(r_blend))
                                              : $signed(18'(Q16_HALF) - 18'(r_blend));
    assign w_prod      = w_mul_a * w_mul_b;
    assign w_accr      = r_acc + (r_acc[AW-1] ? AW'(Q16_ROUND) : AW'(0));
    assign w_spd_mul   = w_accr[AW-1:Q16_SHIFT];

    // shared divide-by-constant unit
    assign w_dreq.start = ((r_state == S_SMOOTH) && w_small)
                        || ((r_state == S_MODE) && (r_mode == MODE_THREE));
    assign w_dreq.sel   = (r_state == S_MODE) ? DIV_FIVE : DIV_TEN;
    assign w_dividend   = (r_state == S_MODE) ? DW'(w_bx) : DW'(w_mag9[P+2:0]);

    wsff_cdiv #(
        .W (DW)
    ) u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_dreq),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_out_free = !r_o_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stand   <= CFG_BITS'(STAND_RESET);
            r_three   <= CFG_BITS'(THREE_RESET);
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_blend   <= '0;
            r_held    <= '0;
            r_wheel   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_STAND_TARGET: r_stand <= i_cfg.data;
                    REG_THREE_TARGET: r_three <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_raw_l <= i_item.raw_left;
                        r_raw_r <= w_neg_right;
                        r_mode  <= i_item.mode;
                        r_wheel <= 1'b0;
                        r_state <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    if (w_small) begin
                        r_sneg  <= w_sum9[P+3];
                        r_state <= S_SDIV;
                    end else if (!r_wheel) begin
                        r_prev_l <= w_half;
                        r_wheel  <= 1'b1;
                        r_state  <= S_SMOOTH;
                    end else begin
                        r_prev_r <= w_half;
                        r_state  <= S_MODE;
                    end
                end
                S_SDIV: begin
                    if (w_div_done) begin
                        if (!r_wheel) begin
                            r_prev_l <= w_qs;
                            r_wheel  <= 1'b1;
                            r_state  <= S_SMOOTH;
                        end else begin
                            r_prev_r <= w_qs;
                            r_state  <= S_MODE;
                        end
                    end
                end
                S_MODE: begin
                    case (r_mode)
                        MODE_STAND: begin
                            r_held  <= f_clamp(CW'(w_avg), r_stand);
                            r_state <= S_DONE;
                        end
                        MODE_THREE: begin
                            r_state <= S_BDIV;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_BDIV: begin
                    if (w_div_done) begin
                        r_blend <= w_quo[BLEND_BITS-1:0];
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    r_acc   <= w_prod;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_acc   <= r_acc + w_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_held  <= f_clamp(CW'(w_spd_mul), r_three);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_speed <= r_held;
                        r_o_fl    <= r_prev_l;
                        r_o_fr    <= r_prev_r;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready         = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_o_valid;
    assign o_res.car_speed      = r_o_speed;
    assign o_res.filtered_left  = r_o_fl;
    assign o_res.filtered_right = r_o_fr;

    `ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready, "item taken while busy")
    `ASSERT_CLK(a_blend_max, i_clk, i_rst_n, r_blend <= BLEND_BITS'(D_MAX), "blend above limit")
    `ASSERT_CLK(a_speed_floor, i_clk, i_rst_n, o_res.valid |-> (o_res.car_speed >= $signed(SPEED_BITS'(SPEED_FLOOR))), "speed below floor")
    `ASSERT_CLK(a_div_done_wait, i_clk, i_rst_n, w_div_done |-> (r_state == S_SDIV || r_state == S_BDIV), "divider done outside wait")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import wsff_pkg::*;

    localparam int PULSE_W         = 16;
    localparam int PULSE_MAX       = 2 ** (PULSE_W - 1) - 1;
    localparam int WHEEL_JUMP      = 20;
    localparam int SPEED_LOW       = -30;
    localparam int SPEED_ROOM      = 30;
    localparam int BLEND_CAP       = 19661;
    localparam int HALF_Q16        = 32768;
    localparam longint ONE_Q16     = 65536;
    localparam int DEV_DIVISOR     = 1400;
    localparam int CFG_MAX         = 2 ** CFG_BITS - 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 125;
    localparam int DIR_N           = 25;

    localparam logic [MODE_BITS-1:0] MODE_HOLD  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic signed [PULSE_W-1:0] raw_l;
        logic signed [PULSE_W-1:0] raw_r;
        logic [MODE_BITS-1:0]      mode;
    } enc_sample_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed;
        logic signed [PULSE_W-1:0]    fl;
        logic signed [PULSE_W-1:0]    fr;
    } fusion_t;

    typedef struct packed {
        logic signed [PULSE_W-1:0]    raw_l;
        logic signed [PULSE_W-1:0]    raw_r;
        logic [MODE_BITS-1:0]         mode;
        logic                         typed;
        logic signed [SPEED_BITS-1:0] speed;
        logic signed [PULSE_W-1:0]    fl;
        logic signed [PULSE_W-1:0]    fr;
    } dir_row_t;

    // the first rows start from reset, so their results are written out
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{16'sd0, 16'sd0, MODE_STAND, 1'b1, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd32767, 16'sh8000, MODE_STAND, 1'b1, 12'sd140, 16'sd16383, 16'sd16383},
        '{16'sh8000, 16'sd32767, MODE_STAND, 1'b1, -12'sd30, -16'sd8192, -16'sd8192},
        '{16'sd5, 16'sd5, MODE_HOLD, 1'b1, -12'sd30, -16'sd4093, -16'sd4098},
        '{16'sd0, 16'sd0, MODE_SPARE, 1'b1, -12'sd30, -16'sd2046, -16'sd2049},
        '{16'sd100, -16'sd100, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd100, -16'sd100, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd100, -16'sd100, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd100, -16'sd100, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd100, -16'sd100, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd110, -16'sd90, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd120, -16'sd120, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd120, -16'sd120, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd130, -16'sd125, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd300, -16'sd50, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd40, -16'sd200, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, MODE_HOLD, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd200, -16'sd200, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd1000, -16'sd1000, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{-16'sd500, 16'sd500, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{-16'sd95, 16'sd95, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sd32767, 16'sh8000, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{16'sh8000, 16'sd32767, MODE_THREE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{-16'sd1, 16'sd1, MODE_SPARE, 1'b0, 12'sd0, 16'sd0, 16'sd0},
        '{-16'sd1, 16'sd1, MODE_STAND, 1'b0, 12'sd0, 16'sd0, 16'sd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wsff_in_if  #(.PULSE_BITS(PULSE_W)) item_if ();
    wsff_out_if #(.PULSE_BITS(PULSE_W)) res_if ();
    wsff_cfg_if                         cfg_if ();

    wheel_speed_filter_fusion_top #(.PULSE_BITS(PULSE_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // filter and fusion state of the predictor
    longint last_left  = 0;
    longint last_right = 0;
    longint last_blend = 0;
    longint last_speed = 0;
    longint tgt_stand  = STAND_RESET;
    longint tgt_three  = THREE_RESET;

    fusion_t fused_q [$];
    int      errors       = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      mode_hits [4] = '{0, 0, 0, 0};
    int      settings_run = 1;
    int      holds_asked  = 0;
    int      holds_served = 0;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint smooth_wheel(input longint now, input longint old);
        if (mag(now - old) < WHEEL_JUMP)
            return (9 * now + old) / 10;
        return (now + old) / 2;
    endfunction

    function automatic longint clamp_speed(input longint v, input longint hi);
        if (v > hi)
            return hi;
        if (v < SPEED_LOW)
            return SPEED_LOW;
        return v;
    endfunction

    function automatic fusion_t fuse_sample(input enc_sample_t s);
        longint  l, r, diff, dq, d, fast, slow, spd;
        fusion_t f;
        l = s.raw_l;
        r = s.raw_r;
        r = -r;
        if (r > PULSE_MAX)
            r = PULSE_MAX;
        l = smooth_wheel(l, last_left);
        r = smooth_wheel(r, last_right);
        spd = last_speed;
        if (s.mode == MODE_STAND) begin
            spd = clamp_speed((l + r) / 2, tgt_stand + SPEED_ROOM);
        end else if (s.mode == MODE_THREE) begin
            diff = mag(l - tgt_three) - mag(r - tgt_three);
            dq = (diff * diff * ONE_Q16) / DEV_DIVISOR;
            if (dq > BLEND_CAP)
                dq = BLEND_CAP;
            d = (4 * dq + last_blend + 2) / 5;
            last_blend = d;
            fast = (l > r) ? l : r;
            slow = (l > r) ? r : l;
            spd = (fast * (HALF_Q16 + d) + slow * (HALF_Q16 - d)) / ONE_Q16;
            spd = clamp_speed(spd, tgt_three + SPEED_ROOM);
        end
        last_speed = spd;
        last_left = l;
        last_right = r;
        f.speed = SPEED_BITS'(spd);
        f.fl = PULSE_W'(l);
        f.fr = PULSE_W'(r);
        return f;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [PULSE_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return {1'b1, {(PULSE_W-1){1'b0}}};
            1: return {1'b0, {(PULSE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return 1;
        endcase
    endfunction

    task automatic report_miss(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic offer_sample(input enc_sample_t s, input bit fixed, input fusion_t fixed_want);
        fusion_t pred;
        item_if.raw_left = s.raw_l;
        item_if.raw_right = s.raw_r;
        item_if.mode = s.mode;
        item_if.valid = 1'b1;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1)
            @(posedge i_clk);
        pred = fuse_sample(s);
        fused_q.push_back(fixed ? fixed_want : pred);
        items_sent++;
        mode_hits[s.mode]++;
        @(negedge i_clk);
    endtask

    task automatic write_target(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data = CFG_BITS'(value);
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        if (idx == REG_STAND_TARGET)
            tgt_stand = value;
        else
            tgt_three = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // result side: random stalls, calm stretches, and long hold-offs on request
    initial begin
        int gap;
        int rx_calm;
        rx_calm = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                res_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                holds_served++;
            end else if (rx_calm > 0) begin
                rx_calm--;
                res_if.ready = 1'b1;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 31) == 0)
                    rx_calm = $urandom_range(20, 100);
                res_if.ready = (gap == 0);
                if (gap > 1)
                    repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        fusion_t want;
        fusion_t got;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.speed = res_if.car_speed;
            got.fl = res_if.filtered_left;
            got.fr = res_if.filtered_right;
            results_seen++;
            if (fused_q.size() == 0) begin
                report_miss($sformatf("result %0d with no item pending: speed %0d left %0d right %0d",
                                      results_seen, got.speed, got.fl, got.fr));
            end else begin
                want = fused_q.pop_front();
                if (got.speed !== want.speed || got.fl !== want.fl || got.fr !== want.fr)
                    report_miss($sformatf(
                        "result %0d: expected speed %0d left %0d right %0d, got %0d %0d %0d",
                        results_seen, want.speed, want.fl, want.fr, got.speed, got.fl, got.fr));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        enc_sample_t smp;
        fusion_t     want;
        int          gap;
        int          tx_calm;
        int          center;
        int          walk_l;
        int          walk_r;
        int          step;
        int          sel;
        int          rnd_idx;
        int          guard;
        int          m;

        item_if.valid = 1'b0;
        item_if.raw_left = '0;
        item_if.raw_right = '0;
        item_if.mode = MODE_STAND;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_STAND_TARGET;
        cfg_if.data = '0;
        tx_calm = 0;
        rnd_idx = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset register values
        for (int k = 0; k < DIR_N; k++) begin
            smp.raw_l = DIR_ROWS[k].raw_l;
            smp.raw_r = DIR_ROWS[k].raw_r;
            smp.mode = DIR_ROWS[k].mode;
            want.speed = DIR_ROWS[k].speed;
            want.fl = DIR_ROWS[k].fl;
            want.fr = DIR_ROWS[k].fr;
            gap = pick_gap();
            if (gap > 0) begin
                item_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            offer_sample(smp, DIR_ROWS[k].typed, want);
        end

        // random part, one target setting per phase
        for (int p = 0; p < PHASES; p++) begin
            item_if.valid = 1'b0;
            while (fused_q.size() != 0)
                @(negedge i_clk);
            case (p)
                0: begin write_target(REG_STAND_TARGET, 0); write_target(REG_THREE_TARGET, 0); end
                1: begin
                    write_target(REG_STAND_TARGET, CFG_MAX);
                    write_target(REG_THREE_TARGET, CFG_MAX);
                end
                2: begin write_target(REG_STAND_TARGET, CFG_MAX); write_target(REG_THREE_TARGET, 0); end
                3: begin write_target(REG_STAND_TARGET, 0); write_target(REG_THREE_TARGET, CFG_MAX); end
                default: begin
                    write_target(REG_STAND_TARGET, $urandom_range(0, CFG_MAX));
                    write_target(REG_THREE_TARGET, $urandom_range(0, CFG_MAX));
                end
            endcase
            settings_run++;
            center = ($urandom_range(0, 3) == 0) ? int'(tgt_stand) : int'(tgt_three);
            walk_l = center;
            walk_r = center;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    // wheels drifting around the target, mostly small jumps
                    if ($urandom_range(0, 15) == 0 || mag(walk_l - center) > 2000
                            || mag(walk_r - center) > 2000) begin
                        walk_l = center + int'($urandom_range(0, 200)) - 100;
                        walk_r = center + int'($urandom_range(0, 200)) - 100;
                    end else begin
                        step = ($urandom_range(0, 7) == 0) ? 120 : 15;
                        walk_l += int'($urandom_range(0, 2 * step)) - step;
                        walk_r += int'($urandom_range(0, 2 * step)) - step;
                    end
                    smp.raw_l = PULSE_W'(walk_l);
                    smp.raw_r = PULSE_W'(-walk_r);
                end else if (sel < 90) begin
                    smp.raw_l = PULSE_W'($urandom);
                    smp.raw_r = PULSE_W'($urandom);
                end else begin
                    smp.raw_l = pick_extreme();
                    smp.raw_r = pick_extreme();
                end
                m = $urandom_range(0, 19);
                if (m < 8)
                    smp.mode = MODE_THREE;
                else if (m < 15)
                    smp.mode = MODE_STAND;
                else if (m < 18)
                    smp.mode = MODE_HOLD;
                else
                    smp.mode = MODE_SPARE;

                if (rnd_idx == 300 || rnd_idx == 700)
                    holds_asked++;
                rnd_idx++;

                if (tx_calm > 0) begin
                    tx_calm--;
                    gap = 0;
                end else begin
                    gap = pick_gap();
                    if ($urandom_range(0, 31) == 0)
                        tx_calm = $urandom_range(20, 80);
                end
                if (gap > 0) begin
                    item_if.valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                offer_sample(smp, 1'b0, want);
            end
        end
        item_if.valid = 1'b0;

        guard = 0;
        while (fused_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (fused_q.size() != 0)
            report_miss($sformatf("no result for pending item, speed %0d expected",
                                  fused_q.pop_front().speed));

        $display("covered %0d items (%0d stand, %0d three, %0d hold) over %0d target settings,",
                 items_sent, mode_hits[MODE_STAND], mode_hits[MODE_THREE],
                 mode_hits[MODE_HOLD] + mode_hits[MODE_SPARE], settings_run);
        $display("%0d results checked, %0d long output hold-offs, %0d mismatches",
                 results_seen, holds_served, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
